>>> rtl/core/scp_pkg.sv
// ----------------------------------------------------------------------------
// scp_pkg
// Shared types and constants of the segment/plane clipper.
// ----------------------------------------------------------------------------
package scp_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    CLIP_KEEP = 2'd0,
    CLIP_POS  = 2'd1,
    CLIP_NEG  = 2'd2
  } clip_status_t;

  // Configuration register indexes
  localparam int CFG_IDX_W = 2;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_NORMAL_X     = 2'd0,
    CFG_NORMAL_Y     = 2'd1,
    CFG_NORMAL_Z     = 2'd2,
    CFG_PLANE_OFFSET = 2'd3
  } cfg_index_t;

  // Classification handed from front to back
  typedef struct packed {
    clip_status_t status;
    logic         div;     // crossing: divide and interpolate
    logic         lv_neg;  // distance falls along the segment
  } clip_ctrl_t;

  localparam int CTRL_W      = $bits(clip_ctrl_t);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

endpackage

>>> rtl/core/scp_cfg_if.sv
// ----------------------------------------------------------------------------
// scp_cfg_if
// Register write channel.
// ----------------------------------------------------------------------------
interface scp_cfg_if import scp_pkg::*; #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CW-1:0]        data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/scp_seg_if.sv
// ----------------------------------------------------------------------------
// scp_seg_if
// Segment input channel.
// ----------------------------------------------------------------------------
interface scp_seg_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic signed [CW-1:0] start_x;
  logic signed [CW-1:0] start_y;
  logic signed [CW-1:0] start_z;
  logic signed [CW-1:0] end_x;
  logic signed [CW-1:0] end_y;
  logic signed [CW-1:0] end_z;
  modport source (output valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  input ready);
  modport sink   (input valid, start_x, start_y, start_z, end_x, end_y, end_z,
                  output ready);
endinterface

>>> rtl/core/scp_clip_if.sv
// ----------------------------------------------------------------------------
// scp_clip_if
// Clip result channel.
// ----------------------------------------------------------------------------
interface scp_clip_if #(parameter int CW = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           clip_status;
  logic signed [CW-1:0] first_x;
  logic signed [CW-1:0] first_y;
  logic signed [CW-1:0] first_z;
  logic signed [CW-1:0] second_x;
  logic signed [CW-1:0] second_y;
  logic signed [CW-1:0] second_z;
  modport source (output valid, clip_status, first_x, first_y, first_z,
                  second_x, second_y, second_z, input ready);
  modport sink   (input valid, clip_status, first_x, first_y, first_z,
                  second_x, second_y, second_z, output ready);
endinterface

>>> rtl/core/scp_front.sv
// ----------------------------------------------------------------------------
// scp_front
// Five-stage front: plane distances, classification, divider operands.
// ----------------------------------------------------------------------------
module scp_front import scp_pkg::*; #(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int W  = 2*CW+3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [CW-1:0] a_in [3],
  input  logic signed [CW-1:0] b_in [3],
  input  logic signed [CW-1:0] normal [3],
  input  logic signed [CW-1:0] offset,
  output logic                 out_valid,
  input  logic                 out_ready,
  output clip_ctrl_t           ctrl_out,
  output logic signed [CW-1:0] a_out [3],
  output logic signed [CW:0]   d_out [3],
  output logic [W-1:0]         num_out,
  output logic [W-1:0]         den_out
);

  localparam int NS = 5;

  logic [NS-1:0] v;
  logic          en;

  logic signed [CW-1:0]   s1_a [3], s2_a [3], s3_a [3], s4_a [3], s5_a [3];
  logic signed [CW:0]     s1_d [3], s2_d [3], s3_d [3], s4_d [3], s5_d [3];
  logic                   s1_same, s2_same, s3_same, s4_same;
  logic signed [2*CW-1:0] s2_pa [3];
  logic signed [2*CW:0]   s2_pd [3];
  logic signed [W-1:0]    s3_da, s3_lv;
  logic                   s4_da_neg, s4_da_zero, s4_lv_zero, s4_lv_neg;
  logic [W-1:0]           s4_num, s4_den, s5_num, s5_den;
  clip_ctrl_t             s5_ctrl, ctrl_next;

  assign en       = !v[NS-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  // Classification of the crossing
  always_comb begin
    ctrl_next.div    = 1'b0;
    ctrl_next.lv_neg = s4_lv_neg;
    if (s4_same) begin
      ctrl_next.status = s4_da_neg ? CLIP_NEG : CLIP_POS;
    end else if (s4_lv_zero) begin
      if (s4_da_neg) ctrl_next.status = CLIP_NEG;
      else if (!s4_da_zero) ctrl_next.status = CLIP_POS;
      else ctrl_next.status = CLIP_KEEP;
    end else if (!s4_da_zero && ((s4_da_neg == s4_lv_neg) || (s4_den < s4_num))) begin
      ctrl_next.status = s4_da_neg ? CLIP_NEG : CLIP_POS;
    end else begin
      ctrl_next.status = CLIP_KEEP;
      ctrl_next.div    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: direction
      s1_same <= (a_in[0] == b_in[0]) && (a_in[1] == b_in[1]) && (a_in[2] == b_in[2]);
      for (int i = 0; i < 3; i++) begin
        s1_a[i] <= a_in[i];
        s1_d[i] <= (CW+1)'(b_in[i]) - (CW+1)'(a_in[i]);
      end
      // stage 2: products
      s2_same <= s1_same;
      for (int i = 0; i < 3; i++) begin
        s2_a[i]  <= s1_a[i];
        s2_d[i]  <= s1_d[i];
        s2_pa[i] <= normal[i] * s1_a[i];
        s2_pd[i] <= normal[i] * s1_d[i];
      end
      // stage 3: sums
      s3_same <= s2_same;
      s3_a    <= s2_a;
      s3_d    <= s2_d;
      s3_da   <= W'(s2_pa[0]) + W'(s2_pa[1]) + W'(s2_pa[2]) - (W'(offset) <<< FB);
      s3_lv   <= W'(s2_pd[0]) + W'(s2_pd[1]) + W'(s2_pd[2]);
      // stage 4: signs and magnitudes
      s4_same    <= s3_same;
      s4_a       <= s3_a;
      s4_d       <= s3_d;
      s4_da_neg  <= s3_da[W-1];
      s4_da_zero <= (s3_da == '0);
      s4_lv_zero <= (s3_lv == '0);
      s4_lv_neg  <= s3_lv[W-1];
      s4_num     <= s3_da[W-1] ? W'(-s3_da) : W'(s3_da);
      s4_den     <= s3_lv[W-1] ? W'(-s3_lv) : W'(s3_lv);
      // stage 5: classify
      s5_ctrl <= ctrl_next;
      s5_a    <= s4_a;
      s5_d    <= s4_d;
      s5_num  <= s4_num;
      s5_den  <= s4_den;
    end
  end

  assign out_valid = v[NS-1];
  assign ctrl_out  = s5_ctrl;
  assign a_out     = s5_a;
  assign d_out     = s5_d;
  assign num_out   = s5_num;
  assign den_out   = s5_den;

endmodule

>>> rtl/core/scp_queue.sv
// ----------------------------------------------------------------------------
// scp_queue
// Small first-in first-out queue between front and back.
// ----------------------------------------------------------------------------
module scp_queue import scp_pkg::*; #(
  parameter int DW = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output logic [DW-1:0] pop_data
);

  logic [DW-1:0]     mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QPTR_W:0]   count;

  assign full      = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + 1'b1;
      if (pop)  rptr <= rptr + 1'b1;
      count <= count + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wptr] <= push_data;
  end

endmodule

>>> rtl/core/scp_back.sv
// ----------------------------------------------------------------------------
// scp_back
// Pipelined restoring divider, interpolation and result register.
// ----------------------------------------------------------------------------
module scp_back import scp_pkg::*; #(
  parameter int CW = 32,
  parameter int FB = 16,
  parameter int W  = 2*CW+3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  clip_ctrl_t           ctrl_in,
  input  logic signed [CW-1:0] a_in [3],
  input  logic signed [CW:0]   d_in [3],
  input  logic [W-1:0]         num_in,
  input  logic [W-1:0]         den_in,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic signed [CW-1:0] first [3],
  output logic signed [CW-1:0] second [3]
);

  localparam int ND = FB + 1;      // one quotient bit per stage
  localparam int NS = ND + 2;      // plus multiply and result stages
  localparam int MW = CW + FB + 3;

  logic [NS-1:0] v;
  logic          en;

  clip_ctrl_t           dv_ctrl [ND];
  logic signed [CW-1:0] dv_a    [ND][3];
  logic signed [CW:0]   dv_d    [ND][3];
  logic [W:0]           dv_rem  [ND];
  logic [W-1:0]         dv_den  [ND];
  logic [FB:0]          dv_q    [ND];

  clip_ctrl_t           m_ctrl;
  logic signed [CW-1:0] m_a [3];
  logic signed [CW:0]   m_d [3];
  logic signed [MW-1:0] m_prod [3];

  logic signed [MW-1:0] step [3];
  logic signed [CW-1:0] pt [3], bt [3];

  assign en       = !v[NS-1] || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (en) begin
      v <= {v[NS-2:0], in_valid};
    end
  end

  for (genvar k = 0; k < ND; k++) begin : g_div
    logic [W:0]   rin;
    logic [W-1:0] dn;
    logic         qb;
    if (k == 0) begin : g_first
      assign rin = {1'b0, num_in};
      assign dn  = den_in;
      always_ff @(posedge clk) begin
        if (en) begin
          dv_ctrl[k] <= ctrl_in;
          dv_a[k]    <= a_in;
          dv_d[k]    <= d_in;
          dv_q[k]    <= (FB+1)'(qb);
        end
      end
    end else begin : g_next
      assign rin = {dv_rem[k-1][W-1:0], 1'b0};
      assign dn  = dv_den[k-1];
      always_ff @(posedge clk) begin
        if (en) begin
          dv_ctrl[k] <= dv_ctrl[k-1];
          dv_a[k]    <= dv_a[k-1];
          dv_d[k]    <= dv_d[k-1];
          dv_q[k]    <= {dv_q[k-1][FB-1:0], qb};
        end
      end
    end
    assign qb = (rin >= {1'b0, dn});
    always_ff @(posedge clk) begin
      if (en) begin
        dv_rem[k] <= qb ? (rin - {1'b0, dn}) : rin;
        dv_den[k] <= dn;
      end
    end
  end

  // Offset along the segment, then the crossing point
  always_ff @(posedge clk) begin
    if (en) begin
      m_ctrl <= dv_ctrl[ND-1];
      m_a    <= dv_a[ND-1];
      m_d    <= dv_d[ND-1];
      for (int i = 0; i < 3; i++) begin
        m_prod[i] <= MW'(dv_d[ND-1][i]) * MW'($signed({1'b0, dv_q[ND-1]}));
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      step[i] = m_prod[i] >>> FB;
      pt[i]   = m_a[i] + step[i][CW-1:0];
      bt[i]   = m_a[i] + m_d[i][CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      status <= m_ctrl.status;
      for (int i = 0; i < 3; i++) begin
        if (m_ctrl.status != CLIP_KEEP) begin
          first[i]  <= '0;
          second[i] <= '0;
        end else if (!m_ctrl.div) begin
          first[i]  <= m_a[i];
          second[i] <= bt[i];
        end else if (m_ctrl.lv_neg) begin
          first[i]  <= m_a[i];
          second[i] <= pt[i];
        end else begin
          first[i]  <= pt[i];
          second[i] <= bt[i];
        end
      end
    end
  end

  assign out_valid = v[NS-1];

endmodule

>>> rtl/core/segment_plane_clip.sv
// ----------------------------------------------------------------------------
// segment_plane_clip
// Clips a 3D segment against the plane n.x = c and returns the kept part.
// ----------------------------------------------------------------------------
// Usage:
//   cfg  : register writes (normal_x, normal_y, normal_z, plane_offset), always
//          ready; write only while no item is in flight.
//   seg  : one item per segment (start and end point, signed fixed point).
//   clip : one item per segment: status, then the kept segment, or zeros
//          when the segment lies wholly on one side.
// Throughput: one item per cycle while clip.ready is high. Every stage is
//   a plain register stage, so the front (distance products and
//   classification) and the back (one quotient bit per stage, then the
//   interpolation multiply) each take a new item every cycle unless stalled.
// Path: a result passes the 5 front stages, the queue and FRAC_BITS + 3
//   back stages before it is valid at the output.
// Reset: clears all valid flags and loads the plane z = 0 with normal +z.
// Stall: when clip.ready drops the back holds in place; the queue keeps the
//   front running until its 4 slots are full before seg.ready drops.
// ----------------------------------------------------------------------------
module segment_plane_clip import scp_pkg::*; #(
  parameter int COORD_WIDTH = 32,
  parameter int FRAC_BITS   = 16
) (
  input logic         clk,
  input logic         rst,
  scp_cfg_if.sink     cfg,
  scp_seg_if.sink     seg,
  scp_clip_if.source  clip
);

  localparam int CW = COORD_WIDTH;
  localparam int W  = ((2*CW > CW+FRAC_BITS) ? 2*CW : CW+FRAC_BITS) + 3;
  localparam int QW = CTRL_W + 3*CW + 3*(CW+1) + 2*W;

  // Plane registers
  logic signed [CW-1:0] normal [3];
  logic signed [CW-1:0] offset;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      normal[0] <= '0;
      normal[1] <= '0;
      normal[2] <= CW'(1) << FRAC_BITS;
      offset    <= '0;
    end else if (cfg.valid) begin
      case (cfg_index_t'(cfg.index))
        CFG_NORMAL_X:     normal[0] <= cfg.data;
        CFG_NORMAL_Y:     normal[1] <= cfg.data;
        CFG_NORMAL_Z:     normal[2] <= cfg.data;
        CFG_PLANE_OFFSET: offset    <= cfg.data;
        default: ;
      endcase
    end
  end

  // Front: distances and classification
  logic signed [CW-1:0] a_in [3], b_in [3];
  logic                 f_valid, f_ready;
  clip_ctrl_t           f_ctrl;
  logic signed [CW-1:0] f_a [3];
  logic signed [CW:0]   f_d [3];
  logic [W-1:0]         f_num, f_den;

  assign a_in = '{seg.start_x, seg.start_y, seg.start_z};
  assign b_in = '{seg.end_x, seg.end_y, seg.end_z};

  scp_front #(.CW(CW), .FB(FRAC_BITS), .W(W)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (seg.valid),
    .in_ready (seg.ready),
    .a_in     (a_in),
    .b_in     (b_in),
    .normal   (normal),
    .offset   (offset),
    .out_valid(f_valid),
    .out_ready(f_ready),
    .ctrl_out (f_ctrl),
    .a_out    (f_a),
    .d_out    (f_d),
    .num_out  (f_num),
    .den_out  (f_den)
  );

  // Queue: pack, hold, unpack
  logic          q_full, q_not_empty, q_pop;
  logic [QW-1:0] q_in, q_out;

  assign f_ready = !q_full;
  assign q_in    = {f_ctrl, f_a[0], f_a[1], f_a[2], f_d[0], f_d[1], f_d[2], f_num, f_den};

  scp_queue #(.DW(QW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_valid && !q_full),
    .push_data(q_in),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .pop_data (q_out)
  );

  clip_ctrl_t           b_ctrl;
  logic signed [CW-1:0] b_a [3];
  logic signed [CW:0]   b_d [3];
  logic [W-1:0]         b_num, b_den;
  logic                 b_ready;
  logic signed [CW-1:0] first [3], second [3];

  assign {b_ctrl, b_a[0], b_a[1], b_a[2], b_d[0], b_d[1], b_d[2], b_num, b_den} = q_out;
  assign q_pop = q_not_empty && b_ready;

  // Back: divide and interpolate
  scp_back #(.CW(CW), .FB(FRAC_BITS), .W(W)) u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (q_not_empty),
    .in_ready (b_ready),
    .ctrl_in  (b_ctrl),
    .a_in     (b_a),
    .d_in     (b_d),
    .num_in   (b_num),
    .den_in   (b_den),
    .out_valid(clip.valid),
    .out_ready(clip.ready),
    .status   (clip.clip_status),
    .first    (first),
    .second   (second)
  );

  assign clip.first_x  = first[0];
  assign clip.first_y  = first[1];
  assign clip.first_z  = first[2];
  assign clip.second_x = second[0];
  assign clip.second_y = second[1];
  assign clip.second_z = second[2];

endmodule

>>> rtl/core/scp_checker.sv
// ----------------------------------------------------------------------------
// scp_checker
// Port-level checks of the clipper's result channel.
// ----------------------------------------------------------------------------
module scp_checker import scp_pkg::*; #(
  parameter int CW = 32
) (
  input logic          clk,
  input logic          rst,
  input logic          out_valid,
  input logic          out_ready,
  input logic [1:0]    status,
  input logic [CW-1:0] first_x,
  input logic [CW-1:0] second_z
);

  // no result right after reset
  a_reset_quiet: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == CLIP_KEEP || status == CLIP_POS || status == CLIP_NEG))
    else $error("illegal status code");

  a_side_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != CLIP_KEEP |-> first_x == '0 && second_z == '0)
    else $error("one-sided result carries nonzero points");

endmodule

bind segment_plane_clip scp_checker #(.CW(COORD_WIDTH)) u_scp_checker (
  .clk      (clk),
  .rst      (rst),
  .out_valid(clip.valid),
  .out_ready(clip.ready),
  .status   (clip.clip_status),
  .first_x  (clip.first_x),
  .second_z (clip.second_z)
);
